FILE: hw/rtl/rsr_pkg.sv
`default_nettype none
package rsr_pkg;

    localparam int DATA_W = 64;
    localparam int BYTES_W = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADV_WORDS = 11;
    localparam int WCNT_W = 4;
    localparam int ACC_W = 22;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADVERT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ICMP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OTHER_TYPE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CODE      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_HOP       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SHORT_PAYLOAD = 3'd6;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_HIGH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LOW  = 2'd3;

    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0]  TYPE_RS      = 8'd133;
    localparam logic [7:0]  TYPE_RA      = 8'd134;
    localparam logic [7:0]  HOP_MAX      = 8'd255;
    localparam logic [7:0]  RA_HOP_LIMIT = 8'd64;
    localparam logic [15:0] ICMP_LEN     = 16'd48;
    localparam logic [15:0] ROUTER_LIFE  = 16'd64800;   // 3 x 21600

    localparam logic [63:0] ADV_W0 = {32'h6000_0000, ICMP_LEN, PROTO_ICMPV6, HOP_MAX};
    localparam logic [63:0] ADV_W7 = 64'h0304_4040_FFFF_FFFF;
    localparam logic [63:0] ADV_W8 = 64'hFFFF_FFFF_0000_0000;

    // checksum share of the fixed words, pseudo-header length and next header
    // (hop limit sits in the upper byte of its 16-bit lane, flags below it)
    localparam logic [ACC_W-1:0] CSUM_FIXED = ACC_W'(
        {8'd0, TYPE_RA} * 256 + 32'(RA_HOP_LIMIT) * 256 + 32'(ROUTER_LIFE)
        + 32'h0304 + 32'h4040 + 32'hFFFF * 4 + 32'(ICMP_LEN) + 32'(PROTO_ICMPV6));

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   src_high;
        logic [DATA_W-1:0]   src_low;
    } job_t;

    function automatic logic [ACC_W-1:0] sum_halves(input logic [63:0] w);
        return ACC_W'(w[63:48]) + ACC_W'(w[47:32]) + ACC_W'(w[31:16]) + ACC_W'(w[15:0]);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rsr_if.sv
`default_nettype none
interface rsr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] in_word;
    logic [3:0]  in_bytes;
    logic        in_last;
    modport source (output valid, in_word, in_bytes, in_last, input ready);
    modport sink (input valid, in_word, in_bytes, in_last, output ready);
endinterface

interface rsr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_status;
    logic [63:0] out_word;
    logic        out_last;
    modport source (output valid, out_status, out_word, out_last, input ready);
    modport sink (input valid, out_status, out_word, out_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsr_front.sv
`default_nettype none
module rsr_front
    import rsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DATA_W-1:0]  in_word,
    input  wire logic [BYTES_W-1:0] in_bytes,
    input  wire logic               in_last,
    output logic                    push,
    output job_t                    push_job,
    input  wire logic               q_full
);

    logic [15:0] bt_reg, bt_next;
    logic [15:0] plen_reg, plen_next;
    logic [7:0]  nh_reg, nh_next, hop_reg, hop_next, typ_reg, typ_next, code_reg, code_next;
    logic [63:0] srch_reg, srch_next, srcl_reg, srcl_next;
    logic [3:0]  n_eff;
    logic [16:0] pos;
    logic [16:0] bt_sum;
    logic [7:0]  b;
    logic [2:0]  idx;
    logic [2:0]  status;
    logic        acc;

    assign in_ready = !q_full;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        n_eff = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
        plen_next = plen_reg;
        nh_next = nh_reg;
        hop_next = hop_reg;
        srch_next = srch_reg;
        srcl_next = srcl_reg;
        typ_next = typ_reg;
        code_next = code_reg;
        pos = '0;
        b = '0;
        idx = '0;
        for (int i = 0; i < 8; i++)
        begin
            pos = {1'b0, bt_reg} + 17'(i);
            b = in_word[63-8*i -: 8];
            idx = 3'd7 - pos[2:0];
            if (4'(i) < n_eff)
            begin
                if (pos == 17'd4) plen_next[15:8] = b;
                else if (pos == 17'd5) plen_next[7:0] = b;
                else if (pos == 17'd6) nh_next = b;
                else if (pos == 17'd7) hop_next = b;
                else if (pos >= 17'd8 && pos < 17'd16) srch_next[{idx, 3'b000} +: 8] |= b;
                else if (pos >= 17'd16 && pos < 17'd24) srcl_next[{idx, 3'b000} +: 8] |= b;
                else if (pos == 17'd40) typ_next = b;
                else if (pos == 17'd41) code_next = b;
            end
        end
        bt_sum = {1'b0, bt_reg} + 17'(n_eff);
        bt_next = bt_sum[16] ? 16'hFFFF : bt_sum[15:0];

        if (bt_next < 16'd40) status = ST_TOO_SHORT;
        else if (nh_next != PROTO_ICMPV6) status = ST_NOT_ICMP;
        else if (bt_next < 16'd44) status = ST_TOO_SHORT;
        else if (typ_next != TYPE_RS) status = ST_OTHER_TYPE;
        else if (code_next != 8'd0) status = ST_BAD_CODE;
        else if (hop_next != HOP_MAX) status = ST_BAD_HOP;
        else if (plen_next < 16'd8) status = ST_SHORT_PAYLOAD;
        else status = ST_ADVERT;
    end

    assign push = acc && in_last;
    assign push_job = '{status: status, src_high: srch_next, src_low: srcl_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bt_reg <= '0; plen_reg <= '0; nh_reg <= '0; hop_reg <= '0;
            srch_reg <= '0; srcl_reg <= '0; typ_reg <= '0; code_reg <= '0;
        end
        else if (acc)
        begin
            if (in_last)
            begin
                bt_reg <= '0; plen_reg <= '0; nh_reg <= '0; hop_reg <= '0;
                srch_reg <= '0; srcl_reg <= '0; typ_reg <= '0; code_reg <= '0;
            end
            else
            begin
                bt_reg <= bt_next; plen_reg <= plen_next; nh_reg <= nh_next;
                hop_reg <= hop_next; srch_reg <= srch_next; srcl_reg <= srcl_next;
                typ_reg <= typ_next; code_reg <= code_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rsr_queue.sv
`default_nettype none
module rsr_queue
    import rsr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output logic      q_valid,
    output logic      q_full,
    output job_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              slots_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign q_valid = cnt_reg != '0;
    assign q_full = cnt_reg == CNT_W'(DEPTH);
    assign head = slots_reg[rptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wptr_reg <= bump(wptr_reg);
            if (pop) rptr_reg <= bump(rptr_reg);
            if (push && !pop) cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rsr_back.sv
`default_nettype none
module rsr_back
    import rsr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [DATA_W-1:0]   own_high,
    input  wire logic [DATA_W-1:0]   own_low,
    input  wire logic [DATA_W-1:0]   pfx_high,
    input  wire logic [DATA_W-1:0]   pfx_low,
    input  wire logic                q_valid,
    input  job_t                     head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      out_status,
    output logic [DATA_W-1:0]        out_word,
    output logic                     out_last
);

    logic [WCNT_W-1:0] wcnt_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              ov_reg;
    logic [STATUS_W-1:0] ost_reg;
    logic [DATA_W-1:0] ow_reg;
    logic              ol_reg;
    logic              fire;
    logic [63:0]       word;
    logic [16:0]       f1;
    logic [16:0]       f2;
    logic [15:0]       csum;

    assign fire = q_valid && (!ov_reg || out_ready);
    assign pop = fire && (head.status != ST_ADVERT || wcnt_reg == WCNT_W'(ADV_WORDS - 1));

    always_comb
    begin
        f1 = 17'(acc_reg[15:0]) + 17'(acc_reg[ACC_W-1:16]);
        f2 = 17'(f1[15:0]) + 17'(f1[16]);
        csum = ~f2[15:0];
        case (wcnt_reg)
            4'd0: word = ADV_W0;
            4'd1: word = own_high;
            4'd2: word = own_low;
            4'd3: word = head.src_high;
            4'd4: word = head.src_low;
            4'd5: word = {TYPE_RA, 8'd0, csum, RA_HOP_LIMIT, 8'd0, ROUTER_LIFE};
            4'd6: word = '0;
            4'd7: word = ADV_W7;
            4'd8: word = ADV_W8;
            4'd9: word = pfx_high;
            4'd10: word = pfx_low;
            default: word = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (head.status != ST_ADVERT)
            begin
                ost_reg <= head.status;
                ow_reg <= '0;
                ol_reg <= 1'b1;
            end
            else
            begin
                ost_reg <= ST_ADVERT;
                ow_reg <= word;
                ol_reg <= wcnt_reg == WCNT_W'(ADV_WORDS - 1);
                // checksum builds up while the header words go out
                case (wcnt_reg)
                    4'd0: acc_reg <= CSUM_FIXED + sum_halves(pfx_high) + sum_halves(pfx_low);
                    4'd1, 4'd2, 4'd3, 4'd4: acc_reg <= acc_reg + sum_halves(word);
                    default: acc_reg <= acc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            wcnt_reg <= '0;
        end
        else
        begin
            if (fire) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (pop) wcnt_reg <= '0;
            else if (fire) wcnt_reg <= wcnt_reg + WCNT_W'(1);
        end
    end

    assign out_valid = ov_reg;
    assign out_status = ost_reg;
    assign out_word = ow_reg;
    assign out_last = ol_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/router_solicit_responder.sv
`default_nettype none
// Router Solicitation responder. Packet beats (64-bit words, first byte in
// the top lane) are taken one per cycle while the job queue is not full; the
// parser captures the header and the ICMPv6 type/code and classifies the
// packet on its last beat. A valid solicitation yields an 11-beat Router
// Advertisement (status 0, out_last on the 11th beat); anything else yields
// one status beat with a zero word. The back end sends one beat per cycle
// unless out_ready stalls it, and the job queue (QUEUE_DEPTH entries) absorbs
// packets that end while an advertisement is going out. Each job passes the
// queue slot, then the back end's output register. Config registers are read
// live by the back end and must only be written while idle.
module router_solicit_responder
    import rsr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata,
    rsr_in_if.sink                    in_ch,
    rsr_out_if.source                 out_ch
);

    logic [DATA_W-1:0] own_high_reg, own_low_reg, pfx_high_reg, pfx_low_reg;
    logic push, pop, q_valid, q_full;
    job_t push_job, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_high_reg <= '0;
            own_low_reg <= '0;
            pfx_high_reg <= '0;
            pfx_low_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_HIGH:    own_high_reg <= cfg_wdata;
                CFG_OWN_LOW:     own_low_reg <= cfg_wdata;
                CFG_PREFIX_HIGH: pfx_high_reg <= cfg_wdata;
                CFG_PREFIX_LOW:  pfx_low_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: parse and classify
    rsr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_word(in_ch.in_word), .in_bytes(in_ch.in_bytes), .in_last(in_ch.in_last),
        .push(push), .push_job(push_job), .q_full(q_full)
    );

    // per-packet jobs between parser and reply generator
    rsr_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
        .q_valid(q_valid), .q_full(q_full), .head(head)
    );

    // back: status beat or advertisement burst with checksum
    rsr_back u_back (
        .clk(clk), .rst_n(rst_n),
        .own_high(own_high_reg), .own_low(own_low_reg),
        .pfx_high(pfx_high_reg), .pfx_low(pfx_low_reg),
        .q_valid(q_valid), .head(head), .pop(pop),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_status(out_ch.out_status), .out_word(out_ch.out_word),
        .out_last(out_ch.out_last)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/rsr_checker.sv
`default_nettype none
module rsr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_status,
    input wire logic [63:0] out_word,
    input wire logic        out_last
);

    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != 3'd0 |-> out_word == 64'd0 && out_last)
        else $error("status beat malformed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= 3'd6)
        else $error("status out of range");

    a_advert_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid || out_status != 3'd0
            || out_word[63:32] == 32'h6000_0000)
        else $error("advertisement does not start with IPv6 header");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_status))
        else $error("stalled beat changed");

endmodule

bind router_solicit_responder rsr_checker u_rsr_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.out_status), .out_word(out_ch.out_word),
    .out_last(out_ch.out_last)
);
`default_nettype wire
